/* sv/stmv_pkg.sv */
package stmv_pkg;

  // field widths
  localparam int unsigned ADC_BITS = 10;
  localparam int unsigned SPR_W    = 16;
  localparam int unsigned DEG_W    = 16;
  localparam int unsigned STEPS_W  = 23;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned PROD_W   = 31;
  localparam int unsigned CFG_W    = 16;

  // full scale of the back emf converter
  localparam logic [ADC_BITS-1:0] EMF_FULL = '1;

  // configuration register indexes
  localparam logic REG_STEPS_PER_REV   = 1'b0;
  localparam logic REG_STALL_THRESHOLD = 1'b1;

  // configuration reset values
  localparam logic [SPR_W-1:0]    SPR_RESET = 16'd6400;
  localparam logic [ADC_BITS-1:0] THR_RESET = 10'd125;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_STOP = 2'd2
  } stmv_func_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [DEG_W-1:0] degrees;
    logic                    stall_check;
    logic [ADC_BITS-1:0]     emf_sample;
  } stmv_in_t;

  typedef struct packed {
    logic                    step_pulse;
    logic                    dir_out;
    logic                    is_running;
    logic                    timer_active;
    logic                    sample_used;
    logic signed [POS_W-1:0] position_out;
    logic [STEPS_W-1:0]      steps_remaining;
    logic [ADC_BITS-1:0]     emf_level;
  } stmv_out_t;

endpackage

/* sv/stmv_div360.sv */
module stmv_div360 import stmv_pkg::*; (
  input  logic [PROD_W-1:0]  prod_i,
  output logic [STEPS_W-1:0] quot_o
);

  // x / 360 == (x >> 3) / 45, the latter by reciprocal multiply
  localparam int unsigned NUM_W   = PROD_W - 3;
  localparam int unsigned SHIFT   = 34;
  localparam int unsigned RECIP_W = 29;
  localparam logic [RECIP_W-1:0] RECIP45 = 29'd381774871;

  logic [NUM_W-1:0]         num;
  logic [NUM_W+RECIP_W-1:0] scaled;

  assign num    = prod_i[PROD_W-1:3];
  assign scaled = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(RECIP45);
  assign quot_o = scaled[SHIFT +: STEPS_W];

endmodule

/* sv/stmv_core.sv */
module stmv_core import stmv_pkg::*; #(
  parameter int unsigned MICROSTEPS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  stmv_in_t            item_i,
  input  logic [STEPS_W-1:0]  move_steps_i,
  input  logic [ADC_BITS-1:0] thr_i,
  output stmv_out_t           res_o
);

  // residue of the signed position modulo the microstep count
  localparam int unsigned RW = (MICROSTEPS > 1) ? $clog2(MICROSTEPS) : 1;
  localparam logic [RW:0] MS_VAL   = (RW+1)'(MICROSTEPS);
  localparam logic [RW:0] WRAP_REM = (RW+1)'(64'h1_0000_0000 % MICROSTEPS);

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // filter divide by 3 via reciprocal
  localparam int unsigned SUM_W  = ADC_BITS + 2;
  localparam int unsigned FMUL_W = 26;
  localparam logic [12:0] RECIP3 = 13'd5462;

  logic                dir_q, dir_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ADC_BITS-1:0] avg_q, avg_d;
  logic                run_q, run_d;
  logic                tmr_q, tmr_d;
  logic                stl_q, stl_d;
  logic [RW-1:0]       rem_q, rem_d;

  logic                pulse, used;
  logic [SUM_W-1:0]    filt_sum;
  logic [FMUL_W-1:0]   filt_mul;
  logic [ADC_BITS-1:0] avg_filt;
  logic [RW:0]         rem_fwd, rem_bwd;

  // averaged emf filter: (2*avg + sample) / 3
  assign filt_sum = {1'b0, avg_q, 1'b0} + SUM_W'(item_i.emf_sample);
  assign filt_mul = FMUL_W'(filt_sum) * FMUL_W'(RECIP3);
  assign avg_filt = filt_mul[14 +: ADC_BITS];

  // residue after a forward step, with two's complement wrap
  always_comb begin
    rem_fwd = {1'b0, rem_q} + 1'b1;
    if (rem_fwd == MS_VAL) begin
      rem_fwd = '0;
    end
    if (pos_q == POS_MAX) begin
      if (rem_fwd >= WRAP_REM) begin
        rem_fwd = rem_fwd - WRAP_REM;
      end else begin
        rem_fwd = rem_fwd + MS_VAL - WRAP_REM;
      end
    end
  end

  // residue after a backward step, with two's complement wrap
  always_comb begin
    if (rem_q == '0) begin
      rem_bwd = MS_VAL - 1'b1;
    end else begin
      rem_bwd = {1'b0, rem_q} - 1'b1;
    end
    if (pos_q == POS_MIN) begin
      rem_bwd = rem_bwd + WRAP_REM;
      if (rem_bwd >= MS_VAL) begin
        rem_bwd = rem_bwd - MS_VAL;
      end
    end
  end

  // state update for one transaction
  always_comb begin
    dir_d   = dir_q;
    steps_d = steps_q;
    pos_d   = pos_q;
    avg_d   = avg_q;
    run_d   = run_q;
    tmr_d   = tmr_q;
    stl_d   = stl_q;
    rem_d   = rem_q;
    pulse   = 1'b0;
    used    = 1'b0;
    case (item_i.func)
      FUNC_MOVE: begin
        dir_d   = (item_i.degrees > 16'sd0);
        steps_d = move_steps_i;
        stl_d   = item_i.stall_check;
        if (!run_q) begin
          avg_d = EMF_FULL;
          run_d = 1'b1;
          tmr_d = 1'b1;
        end
      end
      FUNC_STOP: begin
        run_d = 1'b0;
      end
      FUNC_TICK: begin
        if (tmr_q) begin
          if (steps_q != '0) begin
            pulse = 1'b1;
            if (stl_q && (rem_q == '0)) begin
              used  = 1'b1;
              avg_d = avg_filt;
              if (avg_filt < thr_i) begin
                run_d = 1'b0;
              end
            end
            if (dir_q) begin
              pos_d = pos_q + 1'b1;
              rem_d = rem_fwd[RW-1:0];
            end else begin
              pos_d = pos_q - 1'b1;
              rem_d = rem_bwd[RW-1:0];
            end
            steps_d = steps_q - 1'b1;
          end else begin
            run_d = 1'b0;
          end
          if (!run_d) begin
            tmr_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      steps_q <= '0;
      pos_q   <= '0;
      avg_q   <= EMF_FULL;
      run_q   <= 1'b0;
      tmr_q   <= 1'b0;
      stl_q   <= 1'b0;
      rem_q   <= '0;
    end else if (en_i) begin
      dir_q   <= dir_d;
      steps_q <= steps_d;
      pos_q   <= pos_d;
      avg_q   <= avg_d;
      run_q   <= run_d;
      tmr_q   <= tmr_d;
      stl_q   <= stl_d;
      rem_q   <= rem_d;
    end
  end

  // result as seen after this transaction
  always_comb begin
    res_o.step_pulse      = pulse;
    res_o.dir_out         = dir_d;
    res_o.is_running      = run_d;
    res_o.timer_active    = tmr_d;
    res_o.sample_used     = used;
    res_o.position_out    = pos_d;
    res_o.steps_remaining = steps_d;
    res_o.emf_level       = avg_d;
  end

  // a running move always has its timer on
  ast_run_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> tmr_q)
    else $error("running without timer");

  // each pulse consumes exactly one step
  ast_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && pulse |=> steps_q == $past(steps_q) - 1'b1)
    else $error("step count not decremented");

  // a tick with the timer stopped leaves the motion state alone
  ast_sleep_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.func == FUNC_TICK) && !tmr_q |=> $stable(pos_q) && $stable(steps_q))
    else $error("sleeping tick changed state");

endmodule

/* sv/stepper_move_with_stall_detect.sv */
// channel   direction  handshake                  payload
// cfg       in         cfg_we_i                   cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    in_i (stmv_in_t)
// out       out        out_valid_o / out_ready_i  out_o (stmv_out_t)
//
// ticks and stop requests go from the input register straight to the result register
// for a move the angle by steps_per_rev product is registered first, then divided by 360
// one transaction per cycle for ticks while the output is not stalled; the input register
// can still take the next one while a result waits
// reset (async, active low) clears all motion state, emf average to full scale
// a stalled output holds the input register, which then holds in_ready_o low
module stepper_move_with_stall_detect import stmv_pkg::*; #(
  parameter int unsigned MICROSTEPS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stmv_in_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stmv_out_t        out_o
);

  logic [SPR_W-1:0]    spr_q;
  logic [ADC_BITS-1:0] thr_q;

  stmv_in_t            in_q;
  logic                in_valid_q, in_valid_d;
  logic                mul_done_q, mul_done_d;
  logic [PROD_W-1:0]   prod_q;
  stmv_out_t           out_q;
  logic                out_valid_q, out_valid_d;

  logic                is_move;
  logic                out_free;
  logic                retire;
  logic                accept;
  logic [DEG_W:0]      deg_mag;
  logic [DEG_W+SPR_W:0] prod_full;
  logic [STEPS_W-1:0]  move_steps;
  stmv_out_t           res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q <= SPR_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEPS_PER_REV:   spr_q <= cfg_data_i[SPR_W-1:0];
        REG_STALL_THRESHOLD: thr_q <= cfg_data_i[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign is_move     = (in_q.func == FUNC_MOVE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign retire      = in_valid_q && (!is_move || mul_done_q) && out_free;
  assign in_ready_o  = !in_valid_q || retire;
  assign accept      = in_valid_i && in_ready_o;
  assign in_valid_d  = accept ? 1'b1 : (retire ? 1'b0 : in_valid_q);
  assign mul_done_d  = retire ? 1'b0 : (in_valid_q && is_move);
  assign out_valid_d = retire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // step count product of a move: |degrees| * steps_per_rev
  assign deg_mag   = in_q.degrees[DEG_W-1] ? ((DEG_W+1)'(1) << DEG_W) - {1'b0, in_q.degrees}
                                           : {1'b0, in_q.degrees};
  assign prod_full = (DEG_W+SPR_W+1)'(deg_mag) * (DEG_W+SPR_W+1)'(spr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mul_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      mul_done_q  <= mul_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    if (in_valid_q && is_move && !mul_done_q) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (retire) begin
      out_q <= res;
    end
  end

  stmv_div360 u_div360 (
    .prod_i (prod_q),
    .quot_o (move_steps)
  );

  stmv_core #(
    .MICROSTEPS (MICROSTEPS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (retire),
    .item_i       (in_q),
    .move_steps_i (move_steps),
    .thr_i        (thr_q),
    .res_o        (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // product stage only holds while a move waits in the input register
  ast_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done_q |-> in_valid_q && (in_q.func == FUNC_MOVE))
    else $error("product valid without a pending move");

  // a move is never retired before its product is registered
  ast_move_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && (in_q.func == FUNC_MOVE) && !mul_done_q |-> !in_ready_o && !retire)
    else $error("move retired before product");

  // a held result is never overwritten
  ast_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !retire)
    else $error("result overwritten while stalled");

endmodule
